FILE: rtl/pgte_pkg.sv
// ----------------------------------------------------------------------------
// pgte_pkg: shared types and codes for the particle/grid transfer engine
// Operation codes, column/index types and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package pgte_pkg;

    typedef logic [3:0]         t_op;
    typedef logic [3:0]         t_col;
    typedef logic [9:0]         t_idx;
    typedef logic signed [31:0] t_word;

    localparam t_op OP_CLRNODE   = 4'd0;
    localparam t_op OP_CLRPOINT  = 4'd1;
    localparam t_op OP_WRPOINT   = 4'd2;
    localparam t_op OP_WRNODE    = 4'd3;
    localparam t_op OP_RDPOINT   = 4'd4;
    localparam t_op OP_RDNODE    = 4'd5;
    localparam t_op OP_P2G       = 4'd6;
    localparam t_op OP_G2P       = 4'd7;
    localparam t_op OP_NODEGRAD  = 4'd8;
    localparam t_op OP_NODEDIV   = 4'd9;
    localparam t_op OP_POINTGRAD = 4'd10;

    // coefficient select
    localparam logic [1:0] COEF_W  = 2'd0;
    localparam logic [1:0] COEF_GX = 2'd1;
    localparam logic [1:0] COEF_GY = 2'd2;
    localparam logic [1:0] COEF_GZ = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_DIM   = 2'd0;
    localparam logic [1:0] CFG_PCOLS = 2'd1;
    localparam logic [1:0] CFG_NCOLS = 2'd2;

    typedef struct packed {
        logic       cap;       // capture input item
        logic       mem_rd;    // read both stores
        logic       mul;       // register product
        logic       wb;        // accumulate and write target
        logic       wr_zero;   // write zero to target
        logic       wr_data;   // write item data to target
        logic       rd_cap;    // capture read word
        logic       fin;       // load output register
        logic       tgt_node;  // target store is the node store
        logic       negate;    // subtract product
        logic [1:0] coef_sel;
        t_col       p_col;
        t_col       n_col;
    } t_cmd;

    typedef struct packed {
        logic pok;
        logic nok;
    } t_stat;

endpackage

FILE: rtl/pgte_in_if.sv
// ----------------------------------------------------------------------------
// pgte_in_if: input item channel
// Valid/ready handshake carrying one operation item.
// ----------------------------------------------------------------------------
interface pgte_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         operation;
    logic [9:0]         point_index;
    logic [9:0]         node_index;
    logic [3:0]         column;
    logic signed [31:0] data_value;
    logic signed [31:0] weight;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] grad_z;

    modport source (output valid, operation, point_index, node_index, column,
                    data_value, weight, grad_x, grad_y, grad_z, input ready);
    modport sink   (input valid, operation, point_index, node_index, column,
                    data_value, weight, grad_x, grad_y, grad_z, output ready);
endinterface

FILE: rtl/pgte_out_if.sv
// ----------------------------------------------------------------------------
// pgte_out_if: result item channel
// Valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface pgte_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] read_data;
    logic               saturated;

    modport source (output valid, read_data, saturated, input ready);
    modport sink   (input valid, read_data, saturated, output ready);
endinterface

FILE: rtl/pgte_ctrl.sv
// ----------------------------------------------------------------------------
// pgte_ctrl: operation sequencer
// Holds the configuration, decodes each item and steps the term counters
// that drive the datapath's read, multiply and write-back phases.
// ----------------------------------------------------------------------------
module pgte_ctrl
    import pgte_pkg::*;
#(
    parameter int MAX_COLS = 9
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_idx,
    input  logic [3:0] i_cfg_data,
    input  logic       i_in_valid,
    input  t_op        i_op,
    input  t_col       i_col,
    input  logic       i_out_ready,
    input  t_stat      i_stat,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_CLR  = 4'd2;
    localparam logic [3:0] S_WR   = 4'd3;
    localparam logic [3:0] S_RDA  = 4'd4;
    localparam logic [3:0] S_RDB  = 4'd5;
    localparam logic [3:0] S_TERM = 4'd6;
    localparam logic [3:0] S_MUL  = 4'd7;
    localparam logic [3:0] S_ADD  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    localparam logic [3:0] MAXC = 4'(MAX_COLS);

    logic [3:0] r_state, n_state;
    t_op        r_op, n_op;
    t_col       r_col, n_col;
    logic [3:0] r_a, n_a;
    logic [1:0] r_b, n_b;
    logic       r_out_valid, n_out_valid;
    logic [1:0] r_dim;
    logic [3:0] r_pcols, r_ncols;

    logic [3:0] pc, nc, vc, bound_a, lim;
    logic [1:0] bound_b;
    logic [4:0] c;
    logic [2:0] b_inc;
    logic       is_val, term_ok;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim   <= 2'd3;
            r_pcols <= 4'd1;
            r_ncols <= 4'd1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_DIM:   r_dim   <= i_cfg_data[1:0];
                CFG_PCOLS: r_pcols <= i_cfg_data;
                CFG_NCOLS: r_ncols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // loop bounds and term columns
    always_comb begin
        pc      = (r_pcols > MAXC) ? MAXC : r_pcols;
        nc      = (r_ncols > MAXC) ? MAXC : r_ncols;
        vc      = (pc < nc) ? pc : nc;
        is_val  = (r_op == OP_P2G) || (r_op == OP_G2P);
        bound_a = is_val ? vc : ((r_op == OP_NODEGRAD) ? pc : nc);
        bound_b = is_val ? 2'd1 : r_dim;
        lim     = (r_op == OP_NODEGRAD) ? nc : pc;
        c       = 5'(r_b) + 5'(r_a) * 5'(r_dim);
        term_ok = is_val || (c < 5'(lim));
        b_inc   = 3'(r_b) + 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_col <= n_col;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_col       = r_col;
        n_a         = r_a;
        n_b         = r_b;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '0;

        // datapath column and target selection
        o_cmd.negate   = !is_val;
        o_cmd.coef_sel = is_val ? COEF_W : 2'(r_b + 2'd1);
        unique case (r_op)
            OP_CLRNODE, OP_CLRPOINT: begin
                o_cmd.p_col = r_a;
                o_cmd.n_col = r_a;
            end
            OP_P2G, OP_G2P: begin
                o_cmd.p_col = r_a;
                o_cmd.n_col = r_a;
            end
            OP_NODEGRAD: begin
                o_cmd.p_col = r_a;
                o_cmd.n_col = c[3:0];
            end
            OP_NODEDIV, OP_POINTGRAD: begin
                o_cmd.p_col = c[3:0];
                o_cmd.n_col = r_a;
            end
            default: begin
                o_cmd.p_col = r_col;
                o_cmd.n_col = r_col;
            end
        endcase
        o_cmd.tgt_node = (r_op == OP_CLRNODE) || (r_op == OP_WRNODE) ||
                         (r_op == OP_RDNODE) || (r_op == OP_P2G) ||
                         (r_op == OP_NODEGRAD) || (r_op == OP_NODEDIV);

        unique case (r_state)
            S_IDLE: begin
                // no accept while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.cap = 1'b1;
                    n_op      = i_op;
                    n_col     = i_col;
                    n_a       = '0;
                    n_b       = '0;
                    n_state   = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_FIN;
                case (r_op)
                    OP_CLRNODE:  if (i_stat.nok) n_state = S_CLR;
                    OP_CLRPOINT: if (i_stat.pok) n_state = S_CLR;
                    OP_WRPOINT:  if (i_stat.pok && r_col < pc) n_state = S_WR;
                    OP_WRNODE:   if (i_stat.nok && r_col < nc) n_state = S_WR;
                    OP_RDPOINT:  if (i_stat.pok && r_col < pc) n_state = S_RDA;
                    OP_RDNODE:   if (i_stat.nok && r_col < nc) n_state = S_RDA;
                    OP_P2G, OP_G2P, OP_NODEGRAD, OP_NODEDIV, OP_POINTGRAD:
                        if (i_stat.pok && i_stat.nok) n_state = S_TERM;
                    default: ;
                endcase
            end
            S_CLR: begin
                o_cmd.wr_zero = 1'b1;
                if (r_a == MAXC - 4'd1) n_state = S_FIN;
                else n_a = r_a + 4'd1;
            end
            S_WR: begin
                o_cmd.wr_data = 1'b1;
                n_state       = S_FIN;
            end
            S_RDA: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_RDB;
            end
            S_RDB: begin
                o_cmd.rd_cap = 1'b1;
                n_state      = S_FIN;
            end
            S_TERM: begin
                if (r_a >= bound_a || bound_b == 2'd0) begin
                    n_state = S_FIN;
                end else if (term_ok) begin
                    o_cmd.mem_rd = 1'b1;
                    n_state      = S_MUL;
                end else if (b_inc < 3'(bound_b)) begin
                    n_b = b_inc[1:0];
                end else begin
                    n_b = '0;
                    n_a = r_a + 4'd1;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.wb = 1'b1;
                n_state  = S_TERM;
                if (b_inc < 3'(bound_b)) begin
                    n_b = b_inc[1:0];
                end else begin
                    n_b = '0;
                    n_a = r_a + 4'd1;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.fin   = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/pgte_dp.sv
// ----------------------------------------------------------------------------
// pgte_dp: store and multiply-accumulate datapath
// Point and node stores, item registers, one multiplier and the saturating
// accumulator, plus the result register.
// ----------------------------------------------------------------------------
module pgte_dp
    import pgte_pkg::*;
#(
    parameter int POINTS   = 1024,
    parameter int NODES    = 1024,
    parameter int MAX_COLS = 9
) (
    input  logic  i_clk,
    input  t_cmd  i_cmd,
    input  t_idx  i_point_index,
    input  t_idx  i_node_index,
    input  t_word i_data_value,
    input  t_word i_weight,
    input  t_word i_grad_x,
    input  t_word i_grad_y,
    input  t_word i_grad_z,
    output t_stat o_stat,
    output t_word o_read_data,
    output logic  o_saturated
);

    localparam int P_DEPTH = POINTS * MAX_COLS;
    localparam int N_DEPTH = NODES * MAX_COLS;
    localparam int PAW     = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int NAW     = (N_DEPTH > 1) ? $clog2(N_DEPTH) : 1;

    t_word p_mem [P_DEPTH];
    t_word n_mem [N_DEPTH];

    t_idx  r_pidx, r_nidx;
    t_word r_data, r_w, r_gx, r_gy, r_gz;
    t_word r_p_q, r_n_q;
    t_word r_rd, r_o_rd;
    logic  r_sat, r_o_sat;
    logic signed [63:0] r_prod;

    logic [PAW-1:0]     p_addr;
    logic [NAW-1:0]     n_addr;
    t_word              coef, src, tgt, wdata, sum_sat;
    logic signed [47:0] prod_sh;
    logic signed [48:0] sum;
    logic               sum_clip, p_we, n_we;

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_pidx <= i_point_index;
            r_nidx <= i_node_index;
            r_data <= i_data_value;
            r_w    <= i_weight;
            r_gx   <= i_grad_x;
            r_gy   <= i_grad_y;
            r_gz   <= i_grad_z;
        end
    end

    assign o_stat.pok = 32'(r_pidx) < POINTS;
    assign o_stat.nok = 32'(r_nidx) < NODES;

    assign p_addr = PAW'(32'(r_pidx) * MAX_COLS + 32'(i_cmd.p_col));
    assign n_addr = NAW'(32'(r_nidx) * MAX_COLS + 32'(i_cmd.n_col));

    // operand selection and saturating accumulate
    always_comb begin
        case (i_cmd.coef_sel)
            COEF_GX: coef = r_gx;
            COEF_GY: coef = r_gy;
            COEF_GZ: coef = r_gz;
            default: coef = r_w;
        endcase
        src     = i_cmd.tgt_node ? r_p_q : r_n_q;
        tgt     = i_cmd.tgt_node ? r_n_q : r_p_q;
        prod_sh = 48'(r_prod >>> 16);
        sum     = i_cmd.negate ? (49'(tgt) - 49'(prod_sh)) : (49'(tgt) + 49'(prod_sh));
        sum_clip = 1'b1;
        if (sum > 49'sd2147483647)       sum_sat = 32'sh7FFFFFFF;
        else if (sum < -49'sd2147483648) sum_sat = 32'sh80000000;
        else begin
            sum_sat  = sum[31:0];
            sum_clip = 1'b0;
        end
        if (i_cmd.wr_zero)      wdata = '0;
        else if (i_cmd.wr_data) wdata = r_data;
        else                    wdata = sum_sat;
        p_we = (i_cmd.wr_zero || i_cmd.wr_data || i_cmd.wb) && !i_cmd.tgt_node;
        n_we = (i_cmd.wr_zero || i_cmd.wr_data || i_cmd.wb) && i_cmd.tgt_node;
    end

    // point store
    always_ff @(posedge i_clk) begin
        if (p_we) p_mem[p_addr] <= wdata;
        if (i_cmd.mem_rd) r_p_q <= p_mem[p_addr];
    end

    // node store
    always_ff @(posedge i_clk) begin
        if (n_we) n_mem[n_addr] <= wdata;
        if (i_cmd.mem_rd) r_n_q <= n_mem[n_addr];
    end

    // multiplier stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) r_prod <= 64'(coef) * 64'(src);
    end

    // per-item result and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_rd  <= '0;
            r_sat <= 1'b0;
        end else begin
            if (i_cmd.rd_cap) r_rd <= tgt;
            if (i_cmd.wb && sum_clip) r_sat <= 1'b1;
        end
        if (i_cmd.fin) begin
            r_o_rd  <= r_rd;
            r_o_sat <= r_sat;
        end
    end

    assign o_read_data = r_o_rd;
    assign o_saturated = r_o_sat;

endmodule

FILE: rtl/particle_grid_transfer_engine.sv
// ----------------------------------------------------------------------------
// particle_grid_transfer_engine: material-point particle/grid transfer block
// Top level joining the sequencer and the store/MAC datapath.
// ----------------------------------------------------------------------------
// One item is handled at a time. An item that does nothing (unused code, index
// or column out of range) goes straight to its finish step. A map entry steps
// through its multiply-accumulate terms in turn and skips each gradient term
// whose column is past the count. A value transfer has min(point, node columns)
// terms; the gradient kinds walk dimension times columns, of which at most
// MAX_COLS are performed. Each term is a read / multiply / write-back pass
// through the single MAC unit and the one-port-per-store memories. The result
// register lets the next item be accepted while a result waits; an item stalls
// in its finish step while the previous result is still held. Stores hold
// garbage until written.
module particle_grid_transfer_engine
    import pgte_pkg::*;
#(
    parameter int POINTS   = 1024,
    parameter int NODES    = 1024,
    parameter int MAX_COLS = 9
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_idx,
    input  logic [3:0] i_cfg_data,
    pgte_in_if.sink    i_in,
    pgte_out_if.source o_out
);

    t_cmd  cmd;
    t_stat stat;

    pgte_ctrl #(.MAX_COLS(MAX_COLS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in.valid),
        .i_op        (i_in.operation),
        .i_col       (i_in.column),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    pgte_dp #(.POINTS(POINTS), .NODES(NODES), .MAX_COLS(MAX_COLS)) u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_point_index (i_in.point_index),
        .i_node_index  (i_in.node_index),
        .i_data_value  (i_in.data_value),
        .i_weight      (i_in.weight),
        .i_grad_x      (i_in.grad_x),
        .i_grad_y      (i_in.grad_y),
        .i_grad_z      (i_in.grad_z),
        .o_stat        (stat),
        .o_read_data   (o_out.read_data),
        .o_saturated   (o_out.saturated)
    );

    // one item in flight: no accept in the cycle after an accept
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("accepted item while previous still in work");

    // a new result appears only from the finish step
    a_fin_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(cmd.fin))
        else $error("result valid without finish");

    // reads never saturate and MAC items return zero data
    a_rd_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.saturated && o_out.read_data != 32'sd0))
        else $error("read data and saturation together");

endmodule
